// ----- design/text_console_writer_defines.svh -----
// Assertion macros for the text console writer.
// Used by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- design/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic       ACT_PUT      = 1'b0;
  localparam logic       ACT_READ     = 1'b1;
  localparam int         QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  ch;
    logic [10:0] idx;
    logic        in_range;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] lin;
    logic        scrolled;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } res_t;

endpackage

// ----- design/tcw_front.sv -----
// Front end: accepts input items and classifies them into commands.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [7:0]       char_code_i,
  input  logic [10:0]      cell_index_i,
  input  logic             hold_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tcw_pkg::cmd_t    q_data_o
);
  import tcw_pkg::*;

  // hold off while the back end clears the screen after reset
  assign in_ready_o = !q_full_i && !hold_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_data_o.ch       = char_code_i;
    q_data_o.idx      = cell_index_i;
    q_data_o.in_range = (32'(cell_index_i) < CELLS);
    if (action_i == ACT_READ) begin
      q_data_o.kind = CMD_READ;
    end else if (char_code_i == NEWLINE_CODE) begin
      q_data_o.kind = CMD_NEWLINE;
    end else begin
      q_data_o.kind = CMD_PUT;
    end
  end

endmodule

// ----- design/tcw_queue.sv -----
// Short command queue between the front and back ends.
// Depends on tcw_pkg for the command type and depth.
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t data_o
);
  import tcw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  assign full_o  = (count_q == NW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/tcw_back.sv -----
// Back end: cursor state, screen memory, scroll and clear sequencer, result register.
// Depends on tcw_pkg; takes commands from tcw_queue.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    attr_i,
  input  logic          cmd_valid_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcw_pkg::res_t res_o
);
  import tcw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int COPY_N    = COLUMNS * (ROWS - 1);
  localparam int AW        = $clog2(CELLS);
  localparam int LW        = $clog2(CELLS + 1);
  localparam int CLW       = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [15:0]    mem [CELLS];
  logic [15:0]    rd_data_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata;

  logic [2:0]     state_q, state_d;
  logic [LW-1:0]  cp_q, cp_d;
  logic [AW-1:0]  dst_q, dst_d;
  logic           rd_pend_q, rd_pend_d;
  logic [CLW-1:0] col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [LW-1:0]  lin_q, lin_d;
  logic           res_rd_q, res_rd_d;
  logic           res_scr_q, res_scr_d;
  logic           out_valid_q, out_valid_d;
  res_t           out_q, out_d;

  logic           out_free, emit, emit_rd, emit_scr, last_row, last_col, do_scroll;
  logic [LW-1:0]  copy_src;

  assign out_free    = !out_valid_q || out_ready_i;
  assign last_row    = (row_q == RW'(ROWS - 1));
  assign last_col    = (col_q == CLW'(COLUMNS - 1));
  assign copy_src    = cp_q + LW'(COLUMNS);
  assign busy_o      = (state_q == S_INIT);
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d   = state_q;
    cp_d      = cp_q;
    dst_d     = dst_q;
    rd_pend_d = rd_pend_q;
    col_d     = col_q;
    row_d     = row_q;
    lin_d     = lin_q;
    res_rd_d  = res_rd_q;
    res_scr_d = res_scr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = lin_q[AW-1:0];
    mem_wdata = {attr_i, cmd_i.ch};
    mem_raddr = AW'(cmd_i.idx);
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_rd   = 1'b0;
    emit_scr  = 1'b0;
    do_scroll = 1'b0;

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cp_q[AW-1:0];
        mem_wdata = '0;
        cp_d      = cp_q + 1'b1;
        if (cp_q == LW'(CELLS - 1)) begin
          cp_d    = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_READ: begin
              mem_re    = cmd_i.in_range;
              res_rd_d  = cmd_i.in_range;
              res_scr_d = 1'b0;
              state_d   = S_DONE;
            end
            CMD_NEWLINE: begin
              col_d = '0;
              if (last_row) begin
                do_scroll = 1'b1;
                lin_d     = LW'(COPY_N);
              end else begin
                row_d = row_q + 1'b1;
                lin_d = lin_q - LW'(col_q) + LW'(COLUMNS);
              end
            end
            CMD_PUT: begin
              mem_we = 1'b1;
              if (last_col) begin
                col_d = '0;
                if (last_row) begin
                  do_scroll = 1'b1;
                  lin_d     = LW'(COPY_N);
                end else begin
                  row_d = row_q + 1'b1;
                  lin_d = lin_q + 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
                lin_d = lin_q + 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
          if (cmd_i.kind != CMD_READ) begin
            res_rd_d = 1'b0;
            if (do_scroll) begin
              res_scr_d = 1'b1;
              cp_d      = '0;
              rd_pend_d = 1'b0;
              state_d   = S_COPY;
            end else if (out_free) begin
              emit = 1'b1;
            end else begin
              res_scr_d = 1'b0;
              state_d   = S_DONE;
            end
          end
        end
      end
      S_COPY: begin
        // write back the cell read last cycle, read one row further down
        if (rd_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = dst_q;
          mem_wdata = rd_data_q;
        end
        if (cp_q == LW'(COPY_N)) begin
          rd_pend_d = 1'b0;
          state_d   = S_CLEAR;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = copy_src[AW-1:0];
          dst_d     = cp_q[AW-1:0];
          rd_pend_d = 1'b1;
          cp_d      = cp_q + 1'b1;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cp_q[AW-1:0];
        mem_wdata = '0;
        cp_d      = cp_q + 1'b1;
        if (cp_q == LW'(CELLS - 1)) begin
          cp_d    = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_rd  = res_rd_q;
          emit_scr = res_scr_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_d.col    = 7'(col_d);
      out_d.row    = 5'(row_d);
      out_d.lin    = 11'(lin_d);
      out_d.scrolled = emit_scr;
      out_d.ch     = emit_rd ? rd_data_q[7:0] : 8'h00;
      out_d.attr   = emit_rd ? rd_data_q[15:8] : 8'h00;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cp_q        <= '0;
      rd_pend_q   <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      lin_q       <= '0;
      res_rd_q    <= 1'b0;
      res_scr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cp_q        <= cp_d;
      rd_pend_q   <= rd_pend_d;
      col_q       <= col_d;
      row_q       <= row_d;
      lin_q       <= lin_d;
      res_rd_q    <= res_rd_d;
      res_scr_q   <= res_scr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

endmodule

// ----- design/text_console_writer.sv -----
// Text console writer: a COLUMNS x ROWS character screen with cursor and scrolling.
// Input channel (in_valid_i/in_ready_o) takes put and read items; each item yields
// one result on the output channel (out_valid_o/out_ready_i) with the cursor after it.
// A put writes char_code_i with the current attribute at the cursor and advances;
// character 0x0a moves to column 0 of the next row. A read returns one cell.
// The attribute register is loaded through cfg_valid_i/cfg_data_i, always ready.
// Items pass through a two-entry command queue to the back end, which owns the
// single-write, single-read screen memory; the memory port sets the pace:
//   put or newline: one item per cycle sustained while the receiver takes results
//   read: the back end takes no new command until the read result is emitted
//   scroll: the back end takes no new command from pop to result
//   (row copy, then bottom row clear)
// After reset the back end clears the memory, one cell a cycle, before it takes items;
// in_ready_o stays low during that pass, configuration writes are still taken.
// When the receiver stalls, the result register holds; the back end finishes at most
// one more command and the queue then fills, dropping in_ready_o.
`include "text_console_writer_defines.svh"
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_linear_o,
  output logic        scrolled_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);
  import tcw_pkg::*;

  logic [7:0] attr_q;
  logic       busy, q_full, q_push, q_valid, q_pop;
  cmd_t       q_in, q_out;
  res_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= 8'd10;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_front #(
    .CELLS(COLUMNS * ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .hold_i      (busy),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_out)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .attr_i     (attr_q),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_out),
    .cmd_pop_o  (q_pop),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign cursor_col_o    = res.col;
  assign cursor_row_o    = res.row;
  assign cursor_linear_o = res.lin;
  assign scrolled_o      = res.scrolled;
  assign cell_char_o     = res.ch;
  assign cell_attr_o     = res.attr;

  `TCW_ASSERT_IMPL(a_no_accept_in_clear, busy, !in_ready_o && !out_valid_o, "item during clear")
  `TCW_ASSERT_IMPL(a_col_bound, out_valid_o, 32'(cursor_col_o) < COLUMNS, "column out of range")
  `TCW_ASSERT_IMPL(a_scroll_result, out_valid_o && scrolled_o,
    cursor_row_o == 5'(ROWS - 1) && cell_char_o == 8'h00 && cell_attr_o == 8'h00,
    "bad scroll result")
  `TCW_ASSERT(a_pop_needs_entry, !q_pop || q_valid, "pop from empty queue")

endmodule
